>>> design/wrcp_pkg.sv
`default_nettype none
package wrcp_pkg;

  localparam logic [63:0] MAGIC_RIFF_WAVE = 64'h5249_4646_5741_5645;  // "RIFF" .. "WAVE"
  localparam logic [31:0] ID_FMT          = 32'h666D_7420;            // "fmt "
  localparam logic [31:0] ID_DATA         = 32'h6461_7461;            // "data"
  localparam logic [31:0] FMT_MIN_SIZE    = 32'd16;
  localparam logic [15:0] FORMAT_PCM      = 16'd1;
  localparam logic [15:0] PCM_BITS        = 16'd16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_WAVE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [1:0]  channel_count;
    logic [31:0] pcm_rate;
    logic [30:0] frame_count;
  } res_t;

endpackage
`default_nettype wire

>>> design/wrcp_in_stage.sv
`default_nettype none
module wrcp_in_stage import wrcp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     [7:0] in_byte_i,
  input  wire logic     end_of_file_i,
  output logic          in_stall_o,
  input  wire logic     advance_i,
  output logic          vld_o,
  output in_item_t      item_o
);

  logic     vld_q, vld_d;
  in_item_t item_q;
  logic     accept;

  assign in_stall_o = vld_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.in_byte     <= in_byte_i;
      item_q.end_of_file <= end_of_file_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

>>> design/wrcp_parser.sv
`default_nettype none
module wrcp_parser import wrcp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire in_item_t item_i,
  output logic          has_res_o,
  output res_t          res_o
);

  typedef enum logic [6:0] {
    PH_HDR  = 7'b0000001,
    PH_CHDR = 7'b0000010,
    PH_FMT  = 7'b0000100,
    PH_SKIP = 7'b0001000,
    PH_PAD  = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_IDLE = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] gather_q, gather_d;
  logic [31:0] skip_q, skip_d;
  logic        pad_q, pad_d;
  logic [15:0] tag_q, tag_d;
  logic [15:0] ch_q, ch_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] dlen_q, dlen_d;

  logic [7:0]  b;
  logic        eof;
  logic [63:0] gshift;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic [31:0] skip_dec;
  logic        fmt_ok;
  logic        pv, done, silent;
  logic [1:0]  st;

  assign b          = item_i.in_byte;
  assign eof        = item_i.end_of_file;
  assign gshift     = {gather_q[55:0], b};
  assign chunk_id   = gshift[63:32];
  assign chunk_size = {gshift[7:0], gshift[15:8], gshift[23:16], gshift[31:24]};
  assign skip_dec   = (skip_q != 32'd0) ? (skip_q - 32'd1) : skip_q;

  assign fmt_ok = (tag_q == FORMAT_PCM) && (bits_q == PCM_BITS) &&
                  ((ch_q == 16'd1) || (ch_q == 16'd2)) && (rate_q != 32'd0) &&
                  (dlen_q >= {15'd0, ch_q, 1'b0});

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    gather_d = gather_q;
    skip_d   = skip_q;
    pad_d    = pad_q;
    tag_d    = tag_q;
    ch_d     = ch_q;
    bits_d   = bits_q;
    rate_d   = rate_q;
    dlen_d   = dlen_q;
    pv       = 1'b0;
    done     = 1'b0;
    silent   = 1'b0;
    st       = ST_OK;

    unique case (phase_q)
      PH_HDR: begin
        if (pos_q == 4'd0) begin
          tag_d  = '0;
          ch_d   = '0;
          bits_d = '0;
          rate_d = '0;
          dlen_d = '0;
        end
        // the size field in bytes 4..7 is not kept
        if (pos_q < 4'd4 || pos_q >= 4'd8) begin
          gather_d = gshift;
        end
        pos_d = pos_q + 4'd1;
        if (pos_q == 4'd11) begin
          pos_d = '0;
          if (gshift == MAGIC_RIFF_WAVE) begin
            phase_d = PH_CHDR;
          end else begin
            done = 1'b1;
            st   = ST_NOT_WAVE;
          end
        end
      end
      PH_CHDR: begin
        gather_d = gshift;
        pos_d    = pos_q + 4'd1;
        if (pos_q == 4'd7) begin
          pos_d = '0;
          pad_d = chunk_size[0];
          if (chunk_id == ID_FMT && chunk_size >= FMT_MIN_SIZE) begin
            skip_d  = chunk_size - FMT_MIN_SIZE;
            phase_d = PH_FMT;
          end else if (chunk_id == ID_DATA) begin
            dlen_d = chunk_size;
            skip_d = chunk_size;
            if (chunk_size == 32'd0) begin
              done = 1'b1;
              st   = ST_BAD;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            skip_d = chunk_size;
            // a zero size has no pad byte
            phase_d = (chunk_size != 32'd0) ? PH_SKIP : PH_CHDR;
          end
        end
      end
      PH_FMT: begin
        case (pos_q)
          4'd0:    tag_d[7:0]    = b;
          4'd1:    tag_d[15:8]   = b;
          4'd2:    ch_d[7:0]     = b;
          4'd3:    ch_d[15:8]    = b;
          4'd4:    rate_d[7:0]   = b;
          4'd5:    rate_d[15:8]  = b;
          4'd6:    rate_d[23:16] = b;
          4'd7:    rate_d[31:24] = b;
          4'd14:   bits_d[7:0]   = b;
          4'd15:   bits_d[15:8]  = b;
          default: ;
        endcase
        pos_d = pos_q + 4'd1;
        if (pos_q == 4'd15) begin
          pos_d = '0;
          if (skip_q != 32'd0) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = pad_q ? PH_PAD : PH_CHDR;
          end
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_d = pad_q ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        pad_d   = 1'b0;
        phase_d = PH_CHDR;
      end
      PH_DATA: begin
        pv     = fmt_ok;
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          done = 1'b1;
          st   = fmt_ok ? ST_OK : ST_BAD;
        end
      end
      PH_IDLE: begin
        // trailing bytes: wait for the flagged last byte
        silent = 1'b1;
        if (eof) begin
          phase_d = PH_HDR;
          pos_d   = '0;
        end
      end
      default: begin
        silent  = 1'b1;
        phase_d = PH_HDR;
        pos_d   = '0;
      end
    endcase

    if (!silent) begin
      if (done) begin
        phase_d = eof ? PH_HDR : PH_IDLE;
        pos_d   = '0;
      end else if (eof) begin
        done    = 1'b1;
        st      = (phase_d == PH_HDR) ? ST_NOT_WAVE : ST_BAD;
        phase_d = PH_HDR;
        pos_d   = '0;
      end
    end
  end

  always_comb begin
    has_res_o           = done || pv;
    res_o.payload_byte  = pv ? b : 8'd0;
    res_o.payload_valid = pv;
    res_o.done_res      = done;
    res_o.status        = done ? st : ST_OK;
    res_o.channel_count = '0;
    res_o.pcm_rate      = '0;
    res_o.frame_count   = '0;
    if (done && st == ST_OK) begin
      // channels is 1 or 2 here, so the divide is a shift
      res_o.channel_count = ch_q[1:0];
      res_o.pcm_rate      = rate_q;
      res_o.frame_count   = (ch_q == 16'd1) ? dlen_q[31:1] : {1'b0, dlen_q[31:2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      pos_q    <= '0;
      gather_q <= '0;
      skip_q   <= '0;
      pad_q    <= 1'b0;
      tag_q    <= '0;
      ch_q     <= '0;
      bits_q   <= '0;
      rate_q   <= '0;
      dlen_q   <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      gather_q <= gather_d;
      skip_q   <= skip_d;
      pad_q    <= pad_d;
      tag_q    <= tag_d;
      ch_q     <= ch_d;
      bits_q   <= bits_d;
      rate_q   <= rate_d;
      dlen_q   <= dlen_d;
    end
  end

endmodule
`default_nettype wire

>>> design/wrcp_out_stage.sv
`default_nettype none
module wrcp_out_stage import wrcp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic advance_i,
  input  wire logic has_res_i,
  input  wire res_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  logic vld_q, vld_d;
  res_t res_q;

  // room next edge if empty or the held request leaves now
  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (advance_i) begin
      vld_d = has_res_i;
    end else if (vld_q && !out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && has_res_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

>>> design/wav_riff_chunk_parser.sv
// Flow: a byte accepted into the input register is parsed from that register, and its
//   request, if any, is registered in the output stage when the byte advances.
// Throughput: one byte per cycle while the output is not stalled; the parser state
//   step between the input and result registers sets that figure.
// Reset (async, active low): both stages empty, parser expects a RIFF header.
`default_nettype none
module wav_riff_chunk_parser import wrcp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             payload_valid_o,
  output logic             done_res_o,
  output logic [1:0]       status_o,
  output logic [1:0]       channel_count_o,
  output logic [31:0]      pcm_rate_o,
  output logic [30:0]      frame_count_o
);

  logic     in_vld;
  in_item_t item;
  logic     out_free;
  logic     advance;
  logic     has_res;
  res_t     res_new;
  res_t     res_out;

  assign advance = in_vld && out_free;

  wrcp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .end_of_file_i(end_of_file_i),
    .in_stall_o   (in_stall_o),
    .advance_i    (advance),
    .vld_o        (in_vld),
    .item_o       (item)
  );

  wrcp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (item),
    .has_res_o(has_res),
    .res_o    (res_new)
  );

  wrcp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .has_res_i  (has_res),
    .res_i      (res_new),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign payload_byte_o  = res_out.payload_byte;
  assign payload_valid_o = res_out.payload_valid;
  assign done_res_o      = res_out.done_res;
  assign status_o        = res_out.status;
  assign channel_count_o = res_out.channel_count;
  assign pcm_rate_o      = res_out.pcm_rate;
  assign frame_count_o   = res_out.frame_count;

endmodule
`default_nettype wire
